@@ design/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants of the slab intensity projection block:
// projection modes, register indexes and the job passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

  // sample and result width
  localparam int SAMPLE_W = 16;
  // slab length register width and running sum width
  localparam int LEN_W    = 7;
  localparam int SUM_W    = 23;
  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  // depth of the job queue between front and back
  localparam int JOB_DEPTH = 2;
  // divider: numerator 2*|sum| + count, denominator 2*count
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = LEN_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int STEP_W = $clog2(NUM_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LEN = 1'd1;

  typedef enum logic [1:0] {
    MODE_AVG = 2'd0,
    MODE_MAX = 2'd1,
    MODE_MIN = 2'd2,
    MODE_MID = 2'd3
  } mode_t;

  // one finished slab: either a ready value or a sum still to be divided
  typedef struct packed {
    logic                    is_avg;
    logic signed [SUM_W-1:0] value;
    logic [LEN_W-1:0]        count;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_WRITE = 2'd2
  } bk_state_t;

endpackage

`default_nettype wire

@@ design/sip_front.sv @@
// ----------------------------------------------------------------------------
// sip_front
// Accumulates samples of one slab (sum, max, min, middle sample) and hands a
// job to the back end when the slab is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_front
  import sip_pkg::*;
#(
  parameter int SLAB_MAX = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire mode_t                      mode,
  input  wire logic [LEN_W-1:0]           slab_length,
  output logic                            job_push,
  output job_t                            job
);

  // largest length the register can express, limited by the parameter
  localparam int LenCap = (SLAB_MAX < (2 ** LEN_W - 1)) ? SLAB_MAX : (2 ** LEN_W - 1);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCap);
  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

  logic [LEN_W-1:0]           count_r, count_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] mid_r, mid_nxt;

  logic [LEN_W-1:0]           eff_len;
  logic [LEN_W-1:0]           cnt_inc;
  logic signed [SUM_W-1:0]    sum_inc;
  logic signed [SAMPLE_W-1:0] max_inc, min_inc, mid_inc;
  logic                       done;

  // effective slab length: zero acts as one, clamp at the cap
  always_comb begin
    if (slab_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (slab_length > LEN_CAP) begin
      eff_len = LEN_CAP;
    end else begin
      eff_len = slab_length;
    end
  end

  // accumulator update for the current sample
  always_comb begin
    cnt_inc = count_r + LEN_W'(1);
    sum_inc = sum_r + SUM_W'(sample);
    max_inc = (sample > max_r) ? sample : max_r;
    min_inc = (sample < min_r) ? sample : min_r;
    mid_inc = (count_r == (eff_len >> 1)) ? sample : mid_r;
    done    = (cnt_inc >= eff_len);
  end

  // job contents for a completed slab
  always_comb begin
    job.count  = cnt_inc;
    job.is_avg = 1'b0;
    unique case (mode)
      MODE_AVG: begin
        job.is_avg = 1'b1;
        job.value  = sum_inc;
      end
      MODE_MAX: job.value = SUM_W'(max_inc);
      MODE_MIN: job.value = SUM_W'(min_inc);
      MODE_MID: job.value = SUM_W'(mid_inc);
      default:  job.value = SUM_W'(mid_inc);
    endcase
    job_push = accept && done;
  end

  // next accumulator state: clear after a completed slab
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    mid_nxt   = mid_r;
    if (accept) begin
      if (done) begin
        count_nxt = '0;
        sum_nxt   = '0;
        max_nxt   = MOST_NEG;
        min_nxt   = MOST_POS;
        mid_nxt   = '0;
      end else begin
        count_nxt = cnt_inc;
        sum_nxt   = sum_inc;
        max_nxt   = max_inc;
        min_nxt   = min_inc;
        mid_nxt   = mid_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      max_r   <= MOST_NEG;
      min_r   <= MOST_POS;
      mid_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      mid_r   <= mid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/sip_queue.sv @@
// ----------------------------------------------------------------------------
// sip_queue
// Short job queue between the accumulating front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_queue
  import sip_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  localparam int PtrW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CntW = $clog2(JOB_DEPTH + 1);
  localparam logic [CntW-1:0] DEPTH_C = CntW'(JOB_DEPTH);
  localparam logic [PtrW-1:0] LAST_P  = PtrW'(JOB_DEPTH - 1);

  job_t            slot_r [JOB_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic            do_push, do_pop;

  // status and head
  always_comb begin
    full    = (fill_r == DEPTH_C);
    empty   = (fill_r == '0);
    head    = slot_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && !empty;
  end

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ design/sip_back.sv @@
// ----------------------------------------------------------------------------
// sip_back
// Finishes jobs: passes selected values through, divides slab sums by the
// sample count with a bit-serial divider, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_back
  import sip_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire job_t                       head,
  input  wire logic                       job_empty,
  output logic                            job_pop,
  input  wire logic                       out_pop,
  output logic                            out_empty,
  output logic signed [SAMPLE_W-1:0]      out_value
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  bk_state_t                  state_r, state_nxt;
  logic [NUM_W-1:0]           num_r, num_nxt;
  logic [DEN_W-1:0]           den_r, den_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic                       neg_r, neg_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [SAMPLE_W-1:0]        res_r, res_nxt;
  logic                       oval_r, oval_nxt;
  logic [SAMPLE_W-1:0]        odata_r, odata_nxt;

  logic [SUM_W-1:0]           mag;
  logic [REM_W-1:0]           trial;
  logic                       qbit;
  logic [NUM_W-1:0]           quot;
  logic                       slot_free;

  // divider step and operand preparation
  always_comb begin
    mag       = head.value[SUM_W-1] ? SUM_W'(-head.value) : SUM_W'(head.value);
    trial     = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
    qbit      = (trial >= {1'b0, den_r});
    quot      = {num_r[NUM_W-2:0], qbit};
    slot_free = !oval_r || out_pop;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = head.is_avg ? BK_DIV : BK_WRITE;
        end
      end
      BK_DIV: begin
        if (step_r == LAST_STEP) begin
          state_nxt = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_pop   = 1'b0;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    step_nxt  = step_r;
    res_nxt   = res_r;
    oval_nxt  = oval_r && !out_pop;
    odata_nxt = odata_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop  = 1'b1;
          res_nxt  = head.value[SAMPLE_W-1:0];
          num_nxt  = {mag, 1'b0} + NUM_W'(head.count);
          den_nxt  = {head.count, 1'b0};
          rem_nxt  = '0;
          neg_nxt  = head.value[SUM_W-1];
          step_nxt = '0;
        end
      end
      BK_DIV: begin
        num_nxt  = quot;
        rem_nxt  = qbit ? (trial - {1'b0, den_r}) : trial;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          res_nxt = neg_r ? SAMPLE_W'(-quot[SAMPLE_W-1:0]) : quot[SAMPLE_W-1:0];
        end
      end
      BK_WRITE: begin
        if (slot_free) begin
          oval_nxt  = 1'b1;
          odata_nxt = res_r;
        end
      end
      default: begin
      end
    endcase
    out_empty = !oval_r;
    out_value = odata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      oval_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      step_r  <= step_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
  end

endmodule

`default_nettype wire

@@ design/slab_intensity_projection.sv @@
// ----------------------------------------------------------------------------
// slab_intensity_projection
// Reduces each slab of CT samples to one average, maximum, minimum or middle
// value. A front end accumulates, a two-entry job queue decouples it from a
// back end that divides and holds the result register.
// ----------------------------------------------------------------------------
// back end: max, min and middle values go straight to the result register,
//   averages first pass through a 24-step serial divider
// throughput: one sample per cycle; the back end finishes one slab before it
//   takes the next, the job queue stalls input only when it fills
// reset: mode maximum, slab length 1, accumulators cleared, queues empty
// ----------------------------------------------------------------------------
`default_nettype none

module slab_intensity_projection
  import sip_pkg::*;
#(
  parameter int SLAB_MAX = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       push,
  output logic                            full,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [SAMPLE_W-1:0]      out_projected_value,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  mode_t            mode_r;
  logic [LEN_W-1:0] len_r;

  logic accept;
  logic job_push, job_pop, job_full, job_empty;
  job_t push_job, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MAX;
      len_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     mode_r <= mode_t'(cfg_data[1:0]);
        CFG_SLAB_LEN: len_r  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input transaction
  assign full   = job_full;
  assign accept = push && !full;

  sip_front #(
    .SLAB_MAX (SLAB_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .sample      (in_sample),
    .mode        (mode_r),
    .slab_length (len_r),
    .job_push    (job_push),
    .job         (push_job)
  );

  sip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head),
    .full     (job_full),
    .empty    (job_empty)
  );

  sip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_value (out_projected_value)
  );

  // a completed slab never meets a full job queue
  assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
    else $error("job pushed into full queue");

  // the back end only takes a job that is there
  assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !job_empty)
    else $error("job popped from empty queue");

  // a job taken from the queue leaves it non-full next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (job_pop && !job_push) |=> !job_full)
    else $error("job queue fill lost on pop");

endmodule

`default_nettype wire
